// ===== rtl/core/max_fixed_window_sum_defines.svh =====
`ifndef MAX_FIXED_WINDOW_SUM_DEFINES_SVH
`define MAX_FIXED_WINDOW_SUM_DEFINES_SVH

// property checked outside reset
`define MFWS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// property checked on every edge, reset included
`define MFWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/mfws_pkg.sv =====
`default_nettype none

package mfws_pkg;

    localparam int MAX_WINDOW   = 256;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SUM_WIDTH    = 24;
    localparam int CNT_WIDTH    = $clog2(MAX_WINDOW + 1);
    localparam int WLEN_WIDTH   = 9;

    localparam logic [WLEN_WIDTH-1:0] WLEN_RESET = WLEN_WIDTH'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [SUM_WIDTH-1:0]    t_sum;
    typedef logic [CNT_WIDTH-1:0]           t_cnt;
    typedef logic [WLEN_WIDTH-1:0]          t_wlen;

    typedef struct packed {
        logic accept;
        logic last;
    } t_step;

    // zero counts as one, anything above the chain length saturates
    function automatic t_cnt eff_window(t_wlen wlen);
        t_cnt k;
        if (wlen == '0) begin
            k = t_cnt'(1);
        end else if (int'(wlen) > MAX_WINDOW) begin
            k = t_cnt'(MAX_WINDOW);
        end else begin
            k = t_cnt'(wlen);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mfws_cell.sv =====
`default_nettype none

module mfws_cell (
    input  wire logic              i_clk,
    input  wire logic              i_shift,
    input  wire logic              i_inject,
    input  wire mfws_pkg::t_sample i_new,
    input  wire mfws_pkg::t_sample i_prev,
    output mfws_pkg::t_sample      o_data
);

    mfws_pkg::t_sample r_data;
    mfws_pkg::t_sample n_data;

    always_comb begin
        n_data = r_data;
        if (i_shift) begin
            n_data = i_inject ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/mfws_chain.sv =====
`default_nettype none

// delay line of cells; a new item enters k cells before the end, so the
// last cell shows the item that entered k items ago
module mfws_chain (
    input  wire logic              i_clk,
    input  wire logic              i_shift,
    input  wire mfws_pkg::t_sample i_sample,
    input  wire mfws_pkg::t_cnt    i_k,
    output mfws_pkg::t_sample      o_old
);

    mfws_pkg::t_sample w_link [mfws_pkg::MAX_WINDOW];
    mfws_pkg::t_cnt    w_pos;

    assign w_pos = mfws_pkg::t_cnt'(mfws_pkg::MAX_WINDOW) - i_k;

    for (genvar i = 0; i < mfws_pkg::MAX_WINDOW; i++) begin : g_cell
        mfws_pkg::t_sample w_prev;
        logic              w_inject;

        if (i == 0) begin : g_head
            assign w_prev = i_sample;
        end else begin : g_body
            assign w_prev = w_link[i-1];
        end

        assign w_inject = (w_pos == mfws_pkg::t_cnt'(i));

        mfws_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_inject(w_inject),
            .i_new   (i_sample),
            .i_prev  (w_prev),
            .o_data  (w_link[i])
        );
    end

    assign o_old = w_link[mfws_pkg::MAX_WINDOW-1];

endmodule

`default_nettype wire

// ===== rtl/core/mfws_acc.sv =====
`default_nettype none

`include "max_fixed_window_sum_defines.svh"

module mfws_acc (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mfws_pkg::t_step   i_step,
    input  wire mfws_pkg::t_sample i_sample,
    input  wire mfws_pkg::t_sample i_old,
    input  wire mfws_pkg::t_cnt    i_k,
    input  wire logic              i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output mfws_pkg::t_sum         o_max_sum,
    output logic                   o_valid_res
);

    mfws_pkg::t_sum r_sum, n_sum;
    mfws_pkg::t_sum r_best, n_best;
    mfws_pkg::t_cnt r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;
    mfws_pkg::t_sum r_out_sum, n_out_sum;
    logic           r_out_vres, n_out_vres;

    logic           w_full;
    logic           w_reach;
    mfws_pkg::t_sum w_add;
    mfws_pkg::t_sum w_sub;
    mfws_pkg::t_sum w_new_sum;

    assign o_in_ready = !r_out_valid || i_out_ready;

    assign w_full    = (r_cnt >= i_k);
    assign w_reach   = ((r_cnt + mfws_pkg::t_cnt'(1)) == i_k);
    assign w_add     = mfws_pkg::t_sum'(i_sample);
    assign w_sub     = w_full ? mfws_pkg::t_sum'(i_old) : '0;
    assign w_new_sum = r_sum + w_add - w_sub;

    always_comb begin
        n_sum       = r_sum;
        n_best      = r_best;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_sum   = r_out_sum;
        n_out_vres  = r_out_vres;
        if (i_step.accept) begin
            n_sum = w_new_sum;
            if (!w_full) begin
                n_cnt = r_cnt + mfws_pkg::t_cnt'(1);
                if (w_reach) begin
                    n_best = w_new_sum;
                end
            end else if (w_new_sum > r_best) begin
                n_best = w_new_sum;
            end
            if (i_step.last) begin
                n_out_valid = 1'b1;
                n_out_vres  = w_full || w_reach;
                n_out_sum   = (w_full || w_reach) ? n_best : '0;
                n_sum       = '0;
                n_best      = '0;
                n_cnt       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_best      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_best      <= n_best;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sum  <= n_out_sum;
        r_out_vres <= n_out_vres;
    end

    assign o_out_valid = r_out_valid;
    assign o_max_sum   = r_out_sum;
    assign o_valid_res = r_out_vres;

    `MFWS_ASSERT(a_short_is_zero, i_clk, i_rst_n, (r_out_valid && !r_out_vres) |-> (r_out_sum == '0), "short array result carries a nonzero sum")
    `MFWS_ASSERT(a_clear_on_last, i_clk, i_rst_n, (i_step.accept && i_step.last) |=> ((r_cnt == '0) && (r_sum == '0) && (r_best == '0)), "state not cleared after last item")
    `MFWS_ASSERT(a_last_gives_result, i_clk, i_rst_n, (i_step.accept && i_step.last) |=> r_out_valid, "last item produced no result")
    `MFWS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid, "result pending right after reset")

endmodule

`default_nettype wire

// ===== rtl/core/max_fixed_window_sum.sv =====
// result: registered; it is on o_m_* in the cycle after the last item of an array is accepted
// throughput: one item per cycle; the delay line of sample cells and the window adder
// take a new item every cycle, stalling only while a result waits on i_m_tready
// reset (synchronous, active low): clears sum, count, best sum and the pending
// result, and sets the window length to 3; the sample cells are not cleared
`default_nettype none

module max_fixed_window_sum (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mfws_pkg::WLEN_WIDTH-1:0]   i_cfg_wdata,   // window_length
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [mfws_pkg::SAMPLE_WIDTH-1:0] i_s_tdata,     // [15:0] sample
    input  wire logic                              i_s_tlast,     // last_sample
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [mfws_pkg::SUM_WIDTH-1:0]         o_m_tdata,     // [23:0] max_sum
    output logic                                   o_m_tuser      // valid_res
);

    mfws_pkg::t_wlen   r_wlen, n_wlen;
    mfws_pkg::t_cnt    w_k;
    mfws_pkg::t_step   w_step;
    mfws_pkg::t_sample w_sample;
    mfws_pkg::t_sample w_old;
    mfws_pkg::t_sum    w_max_sum;
    logic              w_in_ready;

    assign n_wlen = i_cfg_we ? i_cfg_wdata : r_wlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= mfws_pkg::WLEN_RESET;
        end else begin
            r_wlen <= n_wlen;
        end
    end

    assign w_k           = mfws_pkg::eff_window(r_wlen);
    assign w_sample      = mfws_pkg::t_sample'(i_s_tdata);
    assign w_step.accept = i_s_tvalid && w_in_ready;
    assign w_step.last   = i_s_tlast;

    mfws_chain u_chain (
        .i_clk   (i_clk),
        .i_shift (w_step.accept),
        .i_sample(w_sample),
        .i_k     (w_k),
        .o_old   (w_old)
    );

    mfws_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_sample   (w_sample),
        .i_old      (w_old),
        .i_k        (w_k),
        .i_out_ready(i_m_tready),
        .o_in_ready (w_in_ready),
        .o_out_valid(o_m_tvalid),
        .o_max_sum  (w_max_sum),
        .o_valid_res(o_m_tuser)
    );

    assign o_s_tready = w_in_ready;
    assign o_m_tdata  = w_max_sum;

endmodule

`default_nettype wire
